[hdl/rna_structure_trimer_histogram_unit_defines.svh]
// assertion macros for the rna structure trimer histogram unit
`ifndef RNA_STRUCTURE_TRIMER_HISTOGRAM_UNIT_DEFINES_SVH
`define RNA_STRUCTURE_TRIMER_HISTOGRAM_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define RSTH_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rsth assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define RSTH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rsth assertion failed");

`endif

[hdl/rsth_pkg.sv]
// shared types and constants for the rna structure trimer histogram unit
package rsth_pkg;

   localparam int BIN_COUNT          = 512;
   localparam int BIN_BITS           = $clog2(BIN_COUNT);
   localparam int TAIL_LEN           = 13;
   localparam int DISTAL_LEN         = 7;
   localparam int SEEN_BITS          = $clog2(TAIL_LEN + 1);
   localparam int RUN_BITS           = 16;
   localparam int INDEX_BITS         = 10;
   localparam int VALUE_BITS         = 32;
   localparam int DEFAULT_COUNT_BITS = 32;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [INDEX_BITS-1:0] IDX_STEM   = INDEX_BITS'(512);
   localparam logic [INDEX_BITS-1:0] IDX_WINDOW = INDEX_BITS'(513);
   localparam logic [INDEX_BITS-1:0] IDX_FLAG   = INDEX_BITS'(514);

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_PUSH  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [2:0] BASE_A = 3'd0;
   localparam logic [2:0] BASE_U = 3'd1;
   localparam logic [2:0] BASE_C = 3'd2;
   localparam logic [2:0] BASE_G = 3'd3;

   localparam logic [1:0] FOLD_DOT   = 2'd0;
   localparam logic [1:0] FOLD_OPEN  = 2'd1;
   localparam logic [1:0] FOLD_CLOSE = 2'd2;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [2:0]            base_code;
      logic [1:0]            fold_symbol;
      logic                  sample_end;
      logic [INDEX_BITS-1:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] read_value;
      logic                  stem_match;
      logic                  terminator_match;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_INC   = 2'd1,
      OP_PASS  = 2'd2,
      OP_READ  = 2'd3
   } op_kind_type;

   // classified transaction handed from front to back
   typedef struct packed {
      op_kind_type           kind;
      logic [BIN_BITS-1:0]   bin_addr;
      logic [INDEX_BITS-1:0] read_index;
      logic                  last;
      logic                  stem_hit;
      logic                  term_hit;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

[hdl/rna_structure_trimer_histogram_unit.sv]
// top level of the rna structure trimer histogram unit
//
//   channel   ports                            handshake
//   request   start, busy, req_payload         taken when start is high and busy low
//   response  rsp_valid, rsp_payload           one-cycle strobe, one per request
//
// the front classifies one request per cycle while the two-entry queue has room and no sweep runs.
// the back reads the bin memory for a bin push or bin read in the idle state, then
// writes or replies in the access state, and takes no new request before that ends;
// other requests are answered from the idle state. a clear request, and reset itself,
// sweeps zeros into all 512 bins with busy held high; a clear's reply shows as it starts.
// results cannot be held off; each shows for exactly one cycle.
`include "rna_structure_trimer_histogram_unit_defines.svh"

module rna_structure_trimer_histogram_unit #(
   parameter int COUNT_BITS = rsth_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rsth_pkg::req_item_type req_payload,
   output logic                   rsp_valid,
   output rsth_pkg::rsp_item_type rsp_payload
);
   import rsth_pkg::*;

   logic             accept;
   logic             pop;
   op_type           front_op;
   op_type           q_head;
   queue_status_type q_status;
   back_status_type  back_status;
   logic             rsp_flagged;

   assign busy   = q_status.full || back_status.clearing;
   assign accept = start && !busy;

   assign rsp_flagged = rsp_valid && (rsp_payload.stem_match || rsp_payload.terminator_match);

   rsth_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .op_out      (front_op)
   );

   rsth_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_op),
      .pop       (pop),
      .head      (q_head),
      .status    (q_status)
   );

   rsth_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .status      (back_status)
   );

   `RSTH_ASSERT_NOW(a_no_push_when_full, accept, !q_status.full)
   `RSTH_ASSERT_NEXT(a_push_lands, accept, !q_status.empty)
   `RSTH_ASSERT_NOW(a_flags_exclude_value, rsp_flagged, rsp_payload.read_value == 0)
   `RSTH_ASSERT_NOW(a_no_pop_while_sweeping, back_status.clearing, !pop)

endmodule

[hdl/rsth_front.sv]
// front end: window tracking, stem-loop and terminator classification
module rsth_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  rsth_pkg::req_item_type req_payload,
   output rsth_pkg::op_type       op_out
);
   import rsth_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_OPEN  = 5'b00010,
      PH_DOT1  = 5'b00100,
      PH_CLOSE = 5'b01000,
      PH_DOT2  = 5'b10000
   } phase_type;

   typedef logic [TAIL_LEN-1:0][2:0] tail_type;

   logic [1:0][2:0]       prior_base_ff, prior_base_in;
   logic [1:0]            prior_pair_ff, prior_pair_in;
   tail_type              tail_ff, tail_in;
   logic [SEEN_BITS-1:0]  seen_ff, seen_in;
   phase_type             phase_ff, phase_in;
   logic [RUN_BITS-1:0]   open_run_ff, open_run_in;
   logic [RUN_BITS-1:0]   close_run_ff, close_run_in;

   logic                  pair;
   logic                  window_ok;
   tail_type              tail_shift;
   logic [SEEN_BITS-1:0]  seen_step;
   phase_type             phase_step;
   logic [RUN_BITS-1:0]   open_step;
   logic [RUN_BITS-1:0]   close_step;
   logic                  stem_hit;
   logic                  term_hit;

   function automatic logic term_check(input tail_type tail, input logic [SEEN_BITS-1:0] seen);
      logic [TAIL_LEN-1:0] is_u;
      logic [TAIL_LEN-1:0] is_acg;
      logic                hairpin;
      for (int i = 0; i < TAIL_LEN; i++) begin
         is_u[i]   = (tail[i] == BASE_U);
         is_acg[i] = (tail[i] == BASE_A) || (tail[i] == BASE_C) || (tail[i] == BASE_G);
      end
      hairpin = 1'b0;
      for (int i = 0; i + 5 <= TAIL_LEN; i++) begin
         if (is_u[i] && is_acg[i+1] && is_acg[i+2] && is_u[i+3] && is_u[i+4]) begin
            hairpin = 1'b1;
         end
      end
      return (seen >= SEEN_BITS'(TAIL_LEN)) && !hairpin &&
             ($countones(is_u) > 2) && (|is_u[TAIL_LEN-1:TAIL_LEN-DISTAL_LEN]);
   endfunction

   assign pair      = (req_payload.fold_symbol != FOLD_DOT);
   assign window_ok = (seen_ff >= SEEN_BITS'(2)) && !prior_base_ff[0][2] &&
                      !prior_base_ff[1][2] && !req_payload.base_code[2];
   assign tail_shift = {req_payload.base_code, tail_ff[TAIL_LEN-1:1]};
   assign seen_step  = (seen_ff == SEEN_BITS'(TAIL_LEN)) ? seen_ff : seen_ff + SEEN_BITS'(1);

   // stem-loop shape tracker
   always_comb begin
      phase_step = phase_ff;
      open_step  = open_run_ff;
      close_step = close_run_ff;
      case (req_payload.fold_symbol)
         FOLD_OPEN: begin
            if (phase_ff == PH_OPEN) begin
               if (open_run_ff != '1) open_step = open_run_ff + RUN_BITS'(1);
            end else begin
               phase_step = PH_OPEN;
               open_step  = RUN_BITS'(1);
               close_step = '0;
            end
         end
         FOLD_DOT: begin
            if (phase_ff == PH_OPEN) phase_step = PH_DOT1;
            else if (phase_ff == PH_CLOSE) phase_step = PH_DOT2;
         end
         FOLD_CLOSE: begin
            if (phase_ff == PH_OPEN || phase_ff == PH_DOT1) begin
               phase_step = PH_CLOSE;
               close_step = RUN_BITS'(1);
            end else if (phase_ff == PH_CLOSE) begin
               if (close_run_ff != '1) close_step = close_run_ff + RUN_BITS'(1);
            end else begin
               phase_step = PH_IDLE;
            end
         end
         default: phase_step = PH_IDLE;
      endcase
   end

   assign stem_hit = ((phase_step == PH_CLOSE) || (phase_step == PH_DOT2)) &&
                     (open_step == close_step);
   assign term_hit = term_check(tail_shift, seen_step);

   always_comb begin
      op_out.kind       = OP_PASS;
      op_out.bin_addr   = {prior_base_ff[0][1:0], prior_base_ff[1][1:0],
                           req_payload.base_code[1:0], prior_pair_ff[0], prior_pair_ff[1], pair};
      op_out.read_index = req_payload.read_index;
      op_out.last       = 1'b0;
      op_out.stem_hit   = 1'b0;
      op_out.term_hit   = 1'b0;

      prior_base_in = prior_base_ff;
      prior_pair_in = prior_pair_ff;
      tail_in       = tail_ff;
      seen_in       = seen_ff;
      phase_in      = phase_ff;
      open_run_in   = open_run_ff;
      close_run_in  = close_run_ff;

      unique case (req_payload.req_type)
         REQ_CLEAR: begin
            op_out.kind   = OP_CLEAR;
            prior_base_in = '0;
            prior_pair_in = '0;
            tail_in       = '0;
            seen_in       = '0;
            phase_in      = PH_IDLE;
            open_run_in   = '0;
            close_run_in  = '0;
         end
         REQ_PUSH: begin
            op_out.kind = window_ok ? OP_INC : OP_PASS;
            op_out.last = req_payload.sample_end;
            if (req_payload.sample_end) begin
               op_out.stem_hit = stem_hit;
               op_out.term_hit = term_hit;
               prior_base_in   = '0;
               prior_pair_in   = '0;
               tail_in         = '0;
               seen_in         = '0;
               phase_in        = PH_IDLE;
               open_run_in     = '0;
               close_run_in    = '0;
            end else begin
               prior_base_in = {req_payload.base_code, prior_base_ff[1]};
               prior_pair_in = {pair, prior_pair_ff[1]};
               tail_in       = tail_shift;
               seen_in       = seen_step;
               phase_in      = phase_step;
               open_run_in   = open_step;
               close_run_in  = close_step;
            end
         end
         REQ_READ: op_out.kind = OP_READ;
         default:  op_out.kind = OP_PASS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_base_ff <= '0;
         prior_pair_ff <= '0;
         tail_ff       <= '0;
         seen_ff       <= '0;
         phase_ff      <= PH_IDLE;
         open_run_ff   <= '0;
         close_run_ff  <= '0;
      end else if (accept) begin
         prior_base_ff <= prior_base_in;
         prior_pair_ff <= prior_pair_in;
         tail_ff       <= tail_in;
         seen_ff       <= seen_in;
         phase_ff      <= phase_in;
         open_run_ff   <= open_run_in;
         close_run_ff  <= close_run_in;
      end
   end

endmodule

[hdl/rsth_queue.sv]
// short fifo of classified transactions between front and back
module rsth_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rsth_pkg::op_type           push_data,
   input  logic                       pop,
   output rsth_pkg::op_type           head,
   output rsth_pkg::queue_status_type status
);
   import rsth_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   op_type                slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   assign status.full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + COUNT_BITS'(1);
      else if (pop && !push) count_in = count_ff - COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[hdl/rsth_back.sv]
// back end: bin memory read-modify-write, totals, reads and clearing sweep
module rsth_back #(
   parameter int COUNT_BITS = rsth_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rsth_pkg::op_type          head,
   input  rsth_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   output rsth_pkg::rsp_item_type    rsp_payload,
   output rsth_pkg::back_status_type status
);
   import rsth_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ACCESS = 3'b010,
      ST_SWEEP  = 3'b100
   } state_type;

   typedef logic [COUNT_BITS-1:0] count_type;

   count_type           bin_mem [BIN_COUNT];
   count_type           rd_data_ff;

   state_type           state_ff, state_in;
   op_type              cur_ff, cur_in;
   logic [BIN_BITS-1:0] sweep_ff, sweep_in;
   count_type           window_total_ff, window_total_in;
   count_type           stem_total_ff, stem_total_in;
   logic                term_flag_ff, term_flag_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;

   logic                mem_we;
   logic [BIN_BITS-1:0] mem_waddr;
   count_type           mem_wdata;
   logic [BIN_BITS-1:0] mem_raddr;

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [VALUE_BITS-1:0] sat_value(input count_type v);
      logic [63:0] wide;
      wide = 64'(v);
      return (wide > 64'h0000_0000_FFFF_FFFF) ? '1 : wide[VALUE_BITS-1:0];
   endfunction

   assign status.clearing = (state_ff == ST_SWEEP);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      sweep_in        = sweep_ff;
      window_total_in = window_total_ff;
      stem_total_in   = stem_total_ff;
      term_flag_in    = term_flag_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = '0;
      pop             = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = cur_ff.bin_addr;
      mem_wdata       = sat_inc(rd_data_ff);
      mem_raddr       = (head.kind == OP_READ) ? head.read_index[BIN_BITS-1:0] : head.bin_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               cur_in = head;
               case (head.kind)
                  OP_CLEAR: begin
                     window_total_in = '0;
                     stem_total_in   = '0;
                     term_flag_in    = 1'b0;
                     sweep_in        = '0;
                     state_in        = ST_SWEEP;
                     rsp_valid_in    = 1'b1;
                  end
                  OP_INC: state_in = ST_ACCESS;
                  OP_READ: begin
                     if (head.read_index < INDEX_BITS'(BIN_COUNT)) begin
                        state_in = ST_ACCESS;
                     end else begin
                        rsp_valid_in = 1'b1;
                        if (head.read_index == IDX_STEM) begin
                           rsp_in.read_value = sat_value(stem_total_ff);
                        end else if (head.read_index == IDX_WINDOW) begin
                           rsp_in.read_value = sat_value(window_total_ff);
                        end else if (head.read_index == IDX_FLAG) begin
                           rsp_in.read_value = VALUE_BITS'(term_flag_ff);
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in            = 1'b1;
                     rsp_in.stem_match       = head.stem_hit;
                     rsp_in.terminator_match = head.term_hit;
                     if (head.last) begin
                        term_flag_in = head.term_hit;
                        if (head.stem_hit) stem_total_in = sat_inc(stem_total_ff);
                     end
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (cur_ff.kind == OP_INC) begin
               mem_we                  = 1'b1;
               window_total_in         = sat_inc(window_total_ff);
               rsp_in.stem_match       = cur_ff.stem_hit;
               rsp_in.terminator_match = cur_ff.term_hit;
               if (cur_ff.last) begin
                  term_flag_in = cur_ff.term_hit;
                  if (cur_ff.stem_hit) stem_total_in = sat_inc(stem_total_ff);
               end
            end else begin
               rsp_in.read_value = sat_value(rd_data_ff);
            end
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + BIN_BITS'(1);
            if (sweep_ff == BIN_BITS'(BIN_COUNT - 1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_SWEEP;
         sweep_ff        <= '0;
         window_total_ff <= '0;
         stem_total_ff   <= '0;
         term_flag_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sweep_ff        <= sweep_in;
         window_total_ff <= window_total_in;
         stem_total_ff   <= stem_total_in;
         term_flag_ff    <= term_flag_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   // bin memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= bin_mem[mem_raddr];
   end

endmodule
